>>> hdl/bsbl_pkg.sv
package bsbl_pkg;

  localparam int TW = 27;
  localparam int PW = 16;
  localparam int SW = 8;
  localparam int LW = 26;
  localparam int EW = 16;
  localparam int MW = 3;
  localparam int CIW = 3;
  localparam int QCW = 5;

  localparam logic [PW-1:0] SLOW_PERIOD_RST = 16'd5000;
  localparam logic [SW-1:0] SLOW_STEPS_RST = 8'd100;
  localparam logic [PW-1:0] FAST_PERIOD_RST = 16'd2500;
  localparam logic [SW-1:0] FAST_STEPS_RST = 8'd50;
  localparam logic [LW-1:0] IDLE_TIMEOUT_RST = 26'd6000000;
  localparam logic [LW-1:0] WRAP_LIMIT_RST = 26'd50000000;

  localparam logic [CIW-1:0] REG_SLOW_PERIOD = 3'd0;
  localparam logic [CIW-1:0] REG_SLOW_STEPS = 3'd1;
  localparam logic [CIW-1:0] REG_FAST_PERIOD = 3'd2;
  localparam logic [CIW-1:0] REG_FAST_STEPS = 3'd3;
  localparam logic [CIW-1:0] REG_IDLE_TIMEOUT = 3'd4;
  localparam logic [CIW-1:0] REG_WRAP_LIMIT = 3'd5;

  localparam logic [MW-1:0] MODE_IDLE = 3'd0;
  localparam logic [MW-1:0] MODE_UPLOAD = 3'd1;
  localparam logic [MW-1:0] MODE_DOWNLOAD = 3'd2;
  localparam logic [MW-1:0] MODE_BL_IDLE = 3'd3;
  localparam logic [MW-1:0] MODE_ERROR = 3'd4;

  localparam logic [1:0] DIV_T_BY_P = 2'd0;
  localparam logic [1:0] DIV_Q_BY_S = 2'd1;
  localparam logic [1:0] DIV_PROD_BY_S = 2'd2;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       mul_en;
    logic       eval_en;
    logic       ch;
    logic       fast;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [MW-1:0] mode;
    logic          div_done;
    logic          out_free;
  } sts_t;

endpackage

>>> hdl/bsbl_div.sv
module bsbl_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [bsbl_pkg::TW-1:0] dividend,
  input  logic [bsbl_pkg::PW-1:0] divisor,
  output logic [bsbl_pkg::TW-1:0] quotient,
  output logic [bsbl_pkg::PW-1:0] remainder,
  output logic                  done
);
  import bsbl_pkg::*;

  logic [TW-1:0]  quo_r, quo_nxt;
  logic [PW-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]  dvs_r;
  logic [QCW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [PW:0]    rem_sh;
  logic           ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[TW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? PW'(rem_sh - {1'b0, dvs_r}) : rem_sh[PW-1:0];
    quo_nxt = {quo_r[TW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == QCW'(TW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

>>> hdl/bsbl_dpath.sv
module bsbl_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bsbl_pkg::cmd_t         cmd,
  output bsbl_pkg::sts_t         sts,
  input  logic [23:0]            in_tdata,
  input  logic                   cfg_valid,
  input  logic [bsbl_pkg::CIW-1:0] cfg_index,
  input  logic [bsbl_pkg::LW-1:0]  cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata
);
  import bsbl_pkg::*;

  logic [PW-1:0] slow_period_r, fast_period_r;
  logic [SW-1:0] slow_steps_r, fast_steps_r;
  logic [LW-1:0] idle_timeout_r, wrap_limit_r;

  logic [TW-1:0]   stopwatch_r;
  logic            jump_r;
  logic [MW-1:0]   mode_r;
  logic [TW-1:0]   q_r;
  logic [PW-1:0]   r_r;
  logic [SW-1:0]   step_r;
  logic            odd_r;
  logic [PW+SW-1:0] prod_r;
  logic [PW-1:0]   duty_r;
  logic            hb_r, al_r;
  logic            out_valid_r;
  logic [2:0]      out_bits_r;

  logic [PW-1:0] p_eff;
  logic [SW-1:0] s_eff;
  logic [TW-1:0] div_a;
  logic [PW-1:0] div_b;
  logic [TW-1:0] div_q;
  logic [PW-1:0] div_r;
  logic          div_done;
  logic [PW-1:0] duty_eff;
  logic          led;
  logic [TW-1:0] sw_wrapped;
  logic          jump_nxt;

  always_comb begin
    p_eff = cmd.fast ? fast_period_r : slow_period_r;
    s_eff = cmd.fast ? fast_steps_r : slow_steps_r;
    if (p_eff == '0) p_eff = PW'(1);
    if (s_eff == '0) s_eff = SW'(1);
    case (cmd.div_sel)
      DIV_Q_BY_S: begin
        div_a = q_r;
        div_b = {{(PW-SW){1'b0}}, s_eff};
      end
      DIV_PROD_BY_S: begin
        div_a = {{(TW-PW-SW){1'b0}}, prod_r};
        div_b = {{(PW-SW){1'b0}}, s_eff};
      end
      default: begin
        div_a = stopwatch_r;
        div_b = p_eff;
      end
    endcase
    duty_eff   = odd_r ? (p_eff - duty_r) : duty_r;
    led        = r_r > duty_eff;
    sw_wrapped = (stopwatch_r > {1'b0, wrap_limit_r}) ? '0 : stopwatch_r;
    jump_nxt   = jump_r | ((mode_r == MODE_BL_IDLE) && (sw_wrapped > {1'b0, idle_timeout_r}));
  end

  bsbl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_period_r  <= SLOW_PERIOD_RST;
      slow_steps_r   <= SLOW_STEPS_RST;
      fast_period_r  <= FAST_PERIOD_RST;
      fast_steps_r   <= FAST_STEPS_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      wrap_limit_r   <= WRAP_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SLOW_PERIOD:  slow_period_r  <= cfg_data[PW-1:0];
        REG_SLOW_STEPS:   slow_steps_r   <= cfg_data[SW-1:0];
        REG_FAST_PERIOD:  fast_period_r  <= cfg_data[PW-1:0];
        REG_FAST_STEPS:   fast_steps_r   <= cfg_data[SW-1:0];
        REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
        REG_WRAP_LIMIT:   wrap_limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopwatch_r <= '0;
      jump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        stopwatch_r <= stopwatch_r + {{(TW-EW){1'b0}}, in_tdata[EW-1:0]};
      end else if (cmd.finish) begin
        stopwatch_r <= sw_wrapped;
        jump_r      <= jump_nxt;
      end
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tdata[EW+MW-1:EW];
      hb_r   <= in_tdata[EW+MW-1:EW] == MODE_BL_IDLE;
      al_r   <= 1'b0;
    end
    if (div_done) begin
      case (cmd.div_sel)
        DIV_Q_BY_S: begin
          odd_r  <= div_q[0];
          step_r <= div_r[SW-1:0];
        end
        DIV_PROD_BY_S: duty_r <= div_q[PW-1:0];
        default: begin
          q_r <= div_q;
          r_r <= div_r;
        end
      endcase
    end
    if (cmd.mul_en) prod_r <= {{SW{1'b0}}, p_eff} * {{PW{1'b0}}, step_r};
    if (cmd.eval_en) begin
      if (cmd.ch) al_r <= led;
      else hb_r <= led;
    end
    if (cmd.finish) out_bits_r <= {jump_nxt, al_r, hb_r};
  end

  assign sts.mode     = mode_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_bits_r};

endmodule

>>> hdl/bsbl_ctrl.sv
module bsbl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  bsbl_pkg::sts_t sts,
  output bsbl_pkg::cmd_t cmd
);
  import bsbl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV1   = 4'd1;
  localparam logic [3:0] S_DIV1_W = 4'd2;
  localparam logic [3:0] S_DIV2   = 4'd3;
  localparam logic [3:0] S_DIV2_W = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_DIV3   = 4'd6;
  localparam logic [3:0] S_DIV3_W = 4'd7;
  localparam logic [3:0] S_EVAL   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       ch_r, ch_nxt;
  logic       need_hb, need_al, hb_fast, al_fast;
  logic [MW-1:0] mode;

  always_comb begin
    mode    = sts.mode;
    need_hb = mode != MODE_BL_IDLE;
    hb_fast = mode == MODE_DOWNLOAD;
    need_al = (mode == MODE_UPLOAD) || (mode >= MODE_ERROR);
    al_fast = mode == MODE_UPLOAD;
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    cmd.ch    = ch_r;
    cmd.fast  = ch_r ? al_fast : hb_fast;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid) state_nxt = S_DIV1;
        ch_nxt = 1'b0;
      end
      S_DIV1: begin
        if (!need_hb && !need_al) begin
          state_nxt = S_OUT;
        end else if (!need_hb && !ch_r) begin
          ch_nxt = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_T_BY_P;
          state_nxt     = S_DIV1_W;
        end
      end
      S_DIV1_W: begin
        cmd.div_sel = DIV_T_BY_P;
        if (sts.div_done) state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_Q_BY_S;
        state_nxt     = S_DIV2_W;
      end
      S_DIV2_W: begin
        cmd.div_sel = DIV_Q_BY_S;
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_DIV3;
      end
      S_DIV3: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PROD_BY_S;
        state_nxt     = S_DIV3_W;
      end
      S_DIV3_W: begin
        cmd.div_sel = DIV_PROD_BY_S;
        if (sts.div_done) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval_en = 1'b1;
        if (!ch_r && need_al) begin
          ch_nxt    = 1'b1;
          state_nxt = S_DIV1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule

>>> hdl/boot_status_breathing_leds_top.sv
// one transaction at a time; a breathing led costs three passes of the shared
// radix-2 divider plus a multiply and a compare
// throughput: next item accepted once the result is in the output register
// reset: synchronous active-low rst_n clears stopwatch and jump flag and reloads
// the default config; no clearing pass
module boot_status_breathing_leds_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // elapsed_us[15:0], mode[18:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // heartbeat_led[0], alarm_led[1], jump_request[2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);
  import bsbl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bsbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsbl_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hdl/bsbl_checker.sv
module bsbl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  logic seen_jump_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_jump_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tdata[2]) begin
      seen_jump_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_jump_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_jump_r |-> out_tdata[2])
    else $error("jump request dropped");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new transaction taken while busy");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:3] == 5'b0)
    else $error("padding bits set");

endmodule

bind boot_status_breathing_leds_top bsbl_checker u_bsbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
